@@ hw/rtl/vjg_pkg.sv @@
// Shared types and constants of the vector job gate register block.
// Used by vjg_dp, vjg_ctrl and the top level; depends on nothing.
package vjg_pkg;

	localparam logic [63:0] ID_VALUE     = 64'h534c_5547_4152_4301;
	localparam logic [63:0] POLICY_VALUE = 64'h534c_5547_0000_0001;
	localparam logic [63:0] WINDOW_NS    = 64'd1000000000;

	// input commands
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TIMER = 2'd2;

	// job status
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_BUSY     = 3'd1;
	localparam logic [2:0] ST_DONE     = 3'd2;
	localparam logic [2:0] ST_PREFAIL  = 3'd3;
	localparam logic [2:0] ST_POSTFAIL = 3'd4;

	// error codes
	localparam logic [2:0] ER_NONE       = 3'd0;
	localparam logic [2:0] ER_EPOCH      = 3'd1;
	localparam logic [2:0] ER_RANGE      = 3'd2;
	localparam logic [2:0] ER_CAPACITY   = 3'd3;
	localparam logic [2:0] ER_REQUEST    = 3'd4;
	localparam logic [2:0] ER_COMPLETION = 3'd5;
	localparam logic [2:0] ER_DESCRIPTOR = 3'd6;

	// job phases
	localparam logic [1:0] PH_COMPUTE = 2'd0;
	localparam logic [1:0] PH_LINK    = 2'd1;
	localparam logic [1:0] PH_RECORD  = 2'd2;

	// descriptor slots
	localparam int D_JEPOCH  = 0;
	localparam int D_JOB     = 1;
	localparam int D_SRC     = 2;
	localparam int D_DST     = 3;
	localparam int D_WORDS   = 4;
	localparam int D_SCALAR  = 5;
	localparam int D_RELEASE = 6;
	localparam int D_FAULT   = 7;

	// timestamp slots
	localparam int T_FINISHED = 0;
	localparam int T_CSTART   = 1;
	localparam int T_CEND     = 2;
	localparam int T_LSTART   = 3;
	localparam int T_LEND     = 4;
	localparam int T_QWAIT    = 5;

	// configuration register indexes
	localparam logic [2:0] CFG_ENFORCE  = 3'd0;
	localparam logic [2:0] CFG_REC_DLY  = 3'd1;
	localparam logic [2:0] CFG_CPW      = 3'd2;
	localparam logic [2:0] CFG_BW       = 3'd3;
	localparam logic [2:0] CFG_LATENCY  = 3'd4;
	localparam logic [2:0] CFG_MEM      = 3'd5;

	// control window offsets
	localparam logic [8:0] OFF_ID       = 9'h000;
	localparam logic [8:0] OFF_STATUS   = 9'h008;
	localparam logic [8:0] OFF_ERROR    = 9'h010;
	localparam logic [8:0] OFF_EPOCH    = 9'h018;
	localparam logic [8:0] OFF_DESC_LO  = 9'h020;
	localparam logic [8:0] OFF_DESC_HI  = 9'h058;
	localparam logic [8:0] OFF_CAP      = 9'h060;
	localparam logic [8:0] OFF_COUNT    = 9'h068;
	localparam logic [8:0] OFF_COMMIT   = 9'h070;
	localparam logic [8:0] OFF_TS_LO    = 9'h078;
	localparam logic [8:0] OFF_TS_HI    = 9'h0a0;
	localparam logic [8:0] OFF_START    = 9'h0a8;
	localparam logic [8:0] OFF_REJECTED = 9'h0b0;
	localparam logic [8:0] OFF_POLICY   = 9'h0b8;
	localparam logic [8:0] OFF_ENFORCE  = 9'h0c0;
	localparam logic [8:0] OFF_REC_DLY  = 9'h0c8;
	localparam logic [8:0] OFF_CPW      = 9'h0d0;
	localparam logic [8:0] OFF_BW       = 9'h0d8;
	localparam logic [8:0] OFF_LATENCY  = 9'h0e0;
	localparam logic [8:0] OFF_REQS     = 9'h0e8;
	localparam logic [8:0] OFF_CMPLS    = 9'h0f0;
	localparam logic [8:0] OFF_FAILS    = 9'h0f8;
	localparam logic [8:0] OFF_NOW      = 9'h100;

	// datapath operations
	localparam logic [4:0] OP_IDLE       = 5'd0;
	localparam logic [4:0] OP_LATCH      = 5'd1;
	localparam logic [4:0] OP_READ       = 5'd2;
	localparam logic [4:0] OP_REJECT     = 5'd3;
	localparam logic [4:0] OP_DESC_WR    = 5'd4;
	localparam logic [4:0] OP_EPOCH_WR   = 5'd5;
	localparam logic [4:0] OP_CAP_WR     = 5'd6;
	localparam logic [4:0] OP_START_INIT = 5'd7;
	localparam logic [4:0] OP_ABORT      = 5'd8;
	localparam logic [4:0] OP_START_MUL  = 5'd9;
	localparam logic [4:0] OP_START_ARM  = 5'd10;
	localparam logic [4:0] OP_LINK_START = 5'd11;
	localparam logic [4:0] OP_LINK_FREE  = 5'd12;
	localparam logic [4:0] OP_LINK_ARM   = 5'd13;
	localparam logic [4:0] OP_COMMIT     = 5'd14;
	localparam logic [4:0] OP_FINISH     = 5'd15;
	localparam logic [4:0] OP_EMIT       = 5'd16;

	typedef struct packed {
		logic [4:0] op;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic       is_read;
		logic       is_write;
		logic       is_timer;
		logic       bad_wr;
		logic       off_desc;
		logic       off_epoch;
		logic       off_cap;
		logic       off_start;
		logic       epoch_ok;
		logic       cap_ok;
		logic       start_ok;
		logic       fail_epoch;
		logic       fail_desc;
		logic       fail_range;
		logic       fail_cap;
		logic       fail_req;
		logic       fail_cmpl;
		logic [1:0] phase;
		logic       div_done;
	} dp_flags_t;

endpackage

@@ hw/rtl/vjg_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameter; used by vjg_dp.
module vjg_div #(
	parameter int NW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [31:0]   den,
	output logic [NW-1:0] quo,
	output logic          rem_nz,
	output logic          done
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [31:0]      rem_q;
	logic [NW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [32:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign quo    = quo_q;
	assign rem_nz = rem_q != '0;
	assign done   = done_q;
endmodule

@@ hw/rtl/vjg_dp.sv @@
// Datapath: latched item, register file, job state, timing arithmetic, result registers.
// Depends on vjg_pkg and vjg_div; driven by vjg_ctrl through dp_cmd_t.
module vjg_dp import vjg_pkg::*; #(
	parameter int RECORD_LIMIT = 1024,
	parameter int WORD_LIMIT   = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  command,
	input  logic [8:0]  reg_offset,
	input  logic [3:0]  access_bytes,
	input  logic [63:0] write_value,
	input  logic [63:0] now_time,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  dp_cmd_t     cmd,
	output dp_flags_t   flags,
	output logic [63:0] read_value,
	output logic        timer_arm,
	output logic [63:0] timer_deadline,
	output logic        commit_pulse
);
	localparam int CW      = $clog2(RECORD_LIMIT + 1);
	localparam int WORDS_W = $clog2(WORD_LIMIT + 1);
	localparam int BYTES_W = WORDS_W + 3;
	localparam int PROD_W  = WORDS_W + 32;

	// latched item
	logic [1:0]  cmd_q;
	logic [8:0]  off_q;
	logic [3:0]  size_q;
	logic [63:0] val_q;
	logic [63:0] now_q;

	// configuration
	logic        enforce_q;
	logic [31:0] rec_dly_q, cpw_q, bw_q, latency_q;
	logic [36:0] mem_q;

	// job state
	logic [2:0]    status_q, error_q;
	logic [63:0]   epoch_q;
	logic [63:0]   desc_q [8];
	logic [63:0]   ts_q [6];
	logic [CW-1:0] cap_q, count_q;
	logic          committed_q;
	logic [1:0]    phase_q;
	logic [63:0]   rej_q, reqs_q, cmpls_q, fails_q;
	logic [63:0]   lft_q;

	logic [PROD_W-1:0] prod_s1;

	// result under construction and the output register
	logic [63:0] wrd_q, wdl_q, ord_q, odl_q;
	logic        warm_q, wcm_q, oarm_q, ocm_q;

	logic [63:0]        words, release_t, fault, rel_now, dly_eff, rd_val;
	logic [WORDS_W-1:0] words_n;
	logic [BYTES_W-1:0] bytes_n;
	logic [31:0]        bw_eff;
	logic [BYTES_W-1:0] quo;
	logic               rem_nz, div_done, aligned;
	logic [CW-1:0]      count_inc;
	logic [2:0]         desc_idx, ts_idx;
	logic [63:0]        lstart;

	function automatic logic span_ok(input logic [63:0] base, input logic [63:0] bytes,
	                                 input logic [36:0] mem);
		logic [63:0] mem64;
		mem64 = 64'(mem);
		return (base[2:0] == 3'd0) && (base <= mem64) && (bytes <= mem64 - base);
	endfunction

	assign words     = desc_q[D_WORDS];
	assign release_t = desc_q[D_RELEASE];
	assign fault     = desc_q[D_FAULT];
	assign words_n   = words[WORDS_W-1:0];
	assign bytes_n   = {words_n, 3'b000};
	assign bw_eff    = (bw_q == '0) ? 32'd1 : bw_q;
	assign rel_now   = release_t - now_q;
	assign dly_eff   = enforce_q ? 64'(rec_dly_q) : 64'd0;
	assign aligned   = (size_q == 4'd8) && (off_q[2:0] == 3'd0);
	assign count_inc = (count_q < CW'(RECORD_LIMIT)) ? count_q + 1'b1 : count_q;
	assign desc_idx  = 3'(off_q[8:3] - OFF_DESC_LO[8:3]);
	assign ts_idx    = 3'(off_q[8:3] - OFF_TS_LO[8:3]);
	assign lstart    = (now_q > lft_q) ? now_q : lft_q;

	vjg_div #(.NW(BYTES_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_LINK_START),
		.num    (bytes_n),
		.den    (bw_eff),
		.quo    (quo),
		.rem_nz (rem_nz),
		.done   (div_done)
	);

	// status toward the controller
	always_comb begin
		flags.is_read    = cmd_q == CMD_READ;
		flags.is_write   = cmd_q == CMD_WRITE;
		flags.is_timer   = (cmd_q == CMD_TIMER) && (status_q == ST_BUSY);
		flags.bad_wr     = !aligned || (status_q == ST_BUSY);
		flags.off_desc   = off_q inside {[OFF_DESC_LO:OFF_DESC_HI]};
		flags.off_epoch  = off_q == OFF_EPOCH;
		flags.off_cap    = off_q == OFF_CAP;
		flags.off_start  = off_q == OFF_START;
		flags.epoch_ok   = val_q > epoch_q;
		flags.cap_ok     = !((val_q < 64'(count_q)) || (val_q > 64'(RECORD_LIMIT)));
		flags.start_ok   = (val_q == 64'd1) && (status_q != ST_PREFAIL) &&
		                   (status_q != ST_POSTFAIL);
		flags.fail_epoch = desc_q[D_JEPOCH] != epoch_q;
		flags.fail_desc  = (words == '0) || (words > 64'(WORD_LIMIT)) || (fault > 64'd3) ||
		                   (release_t < now_q) || (rel_now > WINDOW_NS);
		flags.fail_range = !span_ok(desc_q[D_SRC], 64'(bytes_n), mem_q) ||
		                   !span_ok(desc_q[D_DST], 64'(bytes_n), mem_q);
		flags.fail_cap   = enforce_q && (({1'b0, count_q} + (CW+1)'(2)) > {1'b0, cap_q});
		flags.fail_req   = enforce_q && fault[0];
		flags.fail_cmpl  = enforce_q && fault[1];
		flags.phase      = phase_q;
		flags.div_done   = div_done;
	end

	// register read
	always_comb begin
		rd_val = '0;
		if (aligned) begin
			if (off_q inside {[OFF_DESC_LO:OFF_DESC_HI]})
				rd_val = desc_q[desc_idx];
			else if (off_q inside {[OFF_TS_LO:OFF_TS_HI]})
				rd_val = ts_q[ts_idx];
			else begin
				case (off_q)
					OFF_ID:       rd_val = ID_VALUE;
					OFF_STATUS:   rd_val = 64'(status_q);
					OFF_ERROR:    rd_val = 64'(error_q);
					OFF_EPOCH:    rd_val = epoch_q;
					OFF_CAP:      rd_val = 64'(cap_q);
					OFF_COUNT:    rd_val = 64'(count_q);
					OFF_COMMIT:   rd_val = 64'(committed_q);
					OFF_REJECTED: rd_val = rej_q;
					OFF_POLICY:   rd_val = POLICY_VALUE;
					OFF_ENFORCE:  rd_val = 64'(enforce_q);
					OFF_REC_DLY:  rd_val = 64'(rec_dly_q);
					OFF_CPW:      rd_val = 64'(cpw_q);
					OFF_BW:       rd_val = 64'(bw_q);
					OFF_LATENCY:  rd_val = 64'(latency_q);
					OFF_REQS:     rd_val = reqs_q;
					OFF_CMPLS:    rd_val = cmpls_q;
					OFF_FAILS:    rd_val = fails_q;
					OFF_NOW:      rd_val = now_q;
					default:      rd_val = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			cmd_q  <= command;
			off_q  <= reg_offset;
			size_q <= access_bytes;
			val_q  <= write_value;
			now_q  <= now_time;
		end
		if (cmd.op == OP_START_MUL)
			prod_s1 <= words_n * cpw_q;
		if (cmd.op == OP_EMIT) begin
			ord_q  <= wrd_q;
			oarm_q <= warm_q;
			odl_q  <= wdl_q;
			ocm_q  <= wcm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_q <= 1'b0;
			rec_dly_q <= '0;
			cpw_q     <= '0;
			bw_q      <= 32'd1;
			latency_q <= '0;
			mem_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENFORCE: enforce_q <= cfg_data[0];
				CFG_REC_DLY: rec_dly_q <= cfg_data[31:0];
				CFG_CPW:     cpw_q     <= cfg_data[31:0];
				CFG_BW:      bw_q      <= cfg_data[31:0];
				CFG_LATENCY: latency_q <= cfg_data[31:0];
				CFG_MEM:     mem_q     <= cfg_data[36:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= ST_IDLE;
			error_q     <= ER_NONE;
			epoch_q     <= 64'd1;
			cap_q       <= CW'(RECORD_LIMIT);
			count_q     <= '0;
			committed_q <= 1'b0;
			phase_q     <= PH_COMPUTE;
			lft_q       <= '0;
			rej_q       <= '0;
			reqs_q      <= '0;
			cmpls_q     <= '0;
			fails_q     <= '0;
			for (int i = 0; i < 8; i++) desc_q[i] <= '0;
			for (int i = 0; i < 6; i++) ts_q[i] <= '0;
			wrd_q  <= '0;
			warm_q <= 1'b0;
			wdl_q  <= '0;
			wcm_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LATCH: begin
					wrd_q  <= '0;
					warm_q <= 1'b0;
					wdl_q  <= '0;
					wcm_q  <= 1'b0;
				end
				OP_READ:     wrd_q <= rd_val;
				OP_REJECT:   rej_q <= rej_q + 1'b1;
				OP_DESC_WR:  desc_q[desc_idx] <= val_q;
				OP_EPOCH_WR: begin
					epoch_q     <= val_q;
					count_q     <= '0;
					status_q    <= ST_IDLE;
					error_q     <= ER_NONE;
					committed_q <= 1'b0;
				end
				OP_CAP_WR:   cap_q <= val_q[CW-1:0];
				OP_START_INIT: begin
					committed_q <= 1'b0;
					error_q     <= ER_NONE;
					for (int i = 0; i < 6; i++) ts_q[i] <= '0;
				end
				OP_ABORT: begin
					error_q          <= cmd.code;
					status_q         <= committed_q ? ST_POSTFAIL : ST_PREFAIL;
					ts_q[T_FINISHED] <= now_q;
					fails_q          <= fails_q + 1'b1;
				end
				OP_START_MUL: begin
					if (enforce_q) begin
						count_q <= count_inc;
						reqs_q  <= reqs_q + 1'b1;
					end
					ts_q[T_CSTART] <= release_t + dly_eff;
				end
				OP_START_ARM: begin
					ts_q[T_CEND] <= ts_q[T_CSTART] + 64'(prod_s1);
					wdl_q        <= ts_q[T_CSTART] + 64'(prod_s1);
					warm_q       <= 1'b1;
					phase_q      <= PH_COMPUTE;
					status_q     <= ST_BUSY;
				end
				OP_LINK_START: ts_q[T_LSTART] <= lstart;
				OP_LINK_FREE: begin
					ts_q[T_QWAIT] <= ts_q[T_LSTART] - now_q;
					lft_q         <= ts_q[T_LSTART] + 64'(quo) + 64'(rem_nz);
				end
				OP_LINK_ARM: begin
					ts_q[T_LEND] <= lft_q + 64'(latency_q);
					wdl_q        <= lft_q + 64'(latency_q);
					warm_q       <= 1'b1;
					phase_q      <= PH_LINK;
				end
				OP_COMMIT: begin
					committed_q <= 1'b1;
					wcm_q       <= 1'b1;
					phase_q     <= PH_RECORD;
					wdl_q       <= now_q + dly_eff;
					warm_q      <= 1'b1;
				end
				OP_FINISH: begin
					if (enforce_q) begin
						count_q <= count_inc;
						cmpls_q <= cmpls_q + 1'b1;
					end
					ts_q[T_FINISHED] <= now_q;
					status_q         <= ST_DONE;
				end
				default: ;
			endcase
		end
	end

	assign read_value     = ord_q;
	assign timer_arm      = oarm_q;
	assign timer_deadline = odl_q;
	assign commit_pulse   = ocm_q;
endmodule

@@ hw/rtl/vjg_ctrl.sv @@
// Controller: sequences decode, start checks, phase steps and result hand-off.
// Depends on vjg_pkg; talks to vjg_dp through dp_cmd_t and dp_flags_t.
module vjg_ctrl import vjg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_flags_t flags,
	output dp_cmd_t   cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CHK_A  = 4'd2;
	localparam logic [3:0] S_CHK_B  = 4'd3;
	localparam logic [3:0] S_ARM    = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_LARM   = 4'd6;
	localparam logic [3:0] S_EMIT   = 4'd7;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_IDLE;
		cmd.code = ER_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_EMIT;
				if (flags.is_read)
					cmd.op = OP_READ;
				else if (flags.is_write) begin
					if (flags.bad_wr)
						cmd.op = OP_REJECT;
					else if (flags.off_desc)
						cmd.op = OP_DESC_WR;
					else if (flags.off_epoch)
						cmd.op = flags.epoch_ok ? OP_EPOCH_WR : OP_REJECT;
					else if (flags.off_cap)
						cmd.op = flags.cap_ok ? OP_CAP_WR : OP_REJECT;
					else if (flags.off_start && flags.start_ok) begin
						cmd.op  = OP_START_INIT;
						state_d = S_CHK_A;
					end else
						cmd.op = OP_REJECT;
				end else if (flags.is_timer) begin
					case (flags.phase)
						PH_COMPUTE: begin
							cmd.op  = OP_LINK_START;
							state_d = S_DIV;
						end
						PH_LINK: cmd.op = OP_COMMIT;
						default: begin
							if (flags.fail_cmpl) begin
								cmd.op   = OP_ABORT;
								cmd.code = ER_COMPLETION;
							end else
								cmd.op = OP_FINISH;
						end
					endcase
				end
			end
			S_CHK_A: begin
				state_d = S_EMIT;
				if (flags.fail_epoch) begin
					cmd.op   = OP_ABORT;
					cmd.code = ER_EPOCH;
				end else if (flags.fail_desc) begin
					cmd.op   = OP_ABORT;
					cmd.code = ER_DESCRIPTOR;
				end else
					state_d = S_CHK_B;
			end
			S_CHK_B: begin
				state_d = S_EMIT;
				if (flags.fail_range) begin
					cmd.op   = OP_ABORT;
					cmd.code = ER_RANGE;
				end else if (flags.fail_cap) begin
					cmd.op   = OP_ABORT;
					cmd.code = ER_CAPACITY;
				end else if (flags.fail_req) begin
					cmd.op   = OP_ABORT;
					cmd.code = ER_REQUEST;
				end else begin
					cmd.op  = OP_START_MUL;
					state_d = S_ARM;
				end
			end
			S_ARM: begin
				cmd.op  = OP_START_ARM;
				state_d = S_EMIT;
			end
			S_DIV: begin
				if (flags.div_done) begin
					cmd.op  = OP_LINK_FREE;
					state_d = S_LARM;
				end
			end
			S_LARM: begin
				cmd.op  = OP_LINK_ARM;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |=> out_valid_q)
		else $error("result not presented after emit");
	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && !out_ready) |=> (state_q == S_EMIT))
		else $error("result overwritten while the previous one is pending");
	a_checks_follow_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK_A) |-> $past(state_q == S_DECODE))
		else $error("start checks entered out of sequence");
endmodule

@@ hw/rtl/vector_job_gate_registers.sv @@
// Top level of the vector job gate register block.
// Depends on vjg_pkg, vjg_ctrl, vjg_dp (and vjg_div inside it).
//
//  channel  direction  handshake              payload
//  in       to block   in_valid / in_ready    command, reg_offset, access_bytes,
//                                             write_value, now_time
//  out      from block out_valid / out_ready  read_value, timer_arm,
//                                             timer_deadline, commit_pulse
//  cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction is worked at a time. Reads, plain writes and timer events
// in the commit or record phase pass from acceptance through decode to the
// emit step; a job start runs the epoch and descriptor check, then the range,
// capacity and request check, then arms the compute phase before the emit (a
// failing check goes straight to the emit). A compute-phase timer event runs
// the serial link divider, one quotient bit per cycle, then arms the link phase.
// Reset (arst_n low) clears all job state and configuration at once; no
// clearing pass. A result waits in the output register while the next
// transaction is accepted and worked; it stalls only at hand-off.
module vector_job_gate_registers import vjg_pkg::*; #(
	parameter int RECORD_LIMIT = 1024,
	parameter int WORD_LIMIT   = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [8:0]  reg_offset,
	input  logic [3:0]  access_bytes,
	input  logic [63:0] write_value,
	input  logic [63:0] now_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] read_value,
	output logic        timer_arm,
	output logic [63:0] timer_deadline,
	output logic        commit_pulse,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	dp_cmd_t   cmd;
	dp_flags_t flags;

	// configuration writes are registered directly, always ready
	assign cfg_ready = 1'b1;

	vjg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	vjg_dp #(
		.RECORD_LIMIT (RECORD_LIMIT),
		.WORD_LIMIT   (WORD_LIMIT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (command),
		.reg_offset     (reg_offset),
		.access_bytes   (access_bytes),
		.write_value    (write_value),
		.now_time       (now_time),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.flags          (flags),
		.read_value     (read_value),
		.timer_arm      (timer_arm),
		.timer_deadline (timer_deadline),
		.commit_pulse   (commit_pulse)
	);
endmodule

@@ test/vjg_checker.sv @@
// Checker for the vector job gate register block: predicts each result from
// the accepted transactions and compares it with what the block hands out.
// Depends on vjg_pkg for commands, status and error codes and window offsets.
module vjg_checker import vjg_pkg::*; #(
	parameter int RECORD_LIMIT = 1024,
	parameter int WORD_LIMIT   = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [8:0]  reg_offset,
	input  logic [3:0]  access_bytes,
	input  logic [63:0] write_value,
	input  logic [63:0] now_time,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] read_value,
	input  logic        timer_arm,
	input  logic [63:0] timer_deadline,
	input  logic        commit_pulse,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] rd;
		logic        arm;
		logic [63:0] dl;
		logic        cp;
	} bus_result_t;

	bus_result_t result_q[$];

	logic        enf;
	logic [63:0] rec_dly, cpw, bw, lat, mem_size;
	logic [2:0]  st, err;
	logic [1:0]  ph;
	logic        cmt;
	logic [63:0] ep, cap, cnt, lfree;
	logic [63:0] rej, reqs, cmpls, fails;
	logic [63:0] desc [8];
	logic [63:0] ts [6];

	assign pending = result_q.size();

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic void fail_job(logic [2:0] code, logic [63:0] now);
		err = code;
		st = cmt ? ST_POSTFAIL : ST_PREFAIL;
		ts[T_FINISHED] = now;
		fails++;
	endfunction

	function automatic logic span_fits(logic [63:0] base, logic [63:0] bytes);
		return base[2:0] == 3'd0 && base <= mem_size && bytes <= mem_size - base;
	endfunction

	function automatic void bump_records();
		if (cnt < RECORD_LIMIT)
			cnt++;
	endfunction

	function automatic logic launch_job(logic [63:0] now, output logic [63:0] dl);
		logic [63:0] words, rel, bytes;
		words = desc[D_WORDS];
		rel = desc[D_RELEASE];
		dl = '0;
		cmt = 1'b0;
		err = ER_NONE;
		for (int i = 0; i < 6; i++)
			ts[i] = '0;
		if (desc[D_JEPOCH] != ep) begin
			fail_job(ER_EPOCH, now);
			return 1'b0;
		end
		if (words == 0 || words > WORD_LIMIT || desc[D_FAULT] > 3 ||
				rel < now || rel - now > WINDOW_NS) begin
			fail_job(ER_DESCRIPTOR, now);
			return 1'b0;
		end
		bytes = words * 64'd8;
		if (!span_fits(desc[D_SRC], bytes) || !span_fits(desc[D_DST], bytes)) begin
			fail_job(ER_RANGE, now);
			return 1'b0;
		end
		if (enf && cnt + 2 > cap) begin
			fail_job(ER_CAPACITY, now);
			return 1'b0;
		end
		if (enf && desc[D_FAULT][0]) begin
			fail_job(ER_REQUEST, now);
			return 1'b0;
		end
		if (enf) begin
			bump_records();
			reqs++;
		end
		ts[T_CSTART] = rel + (enf ? rec_dly : 64'd0);
		ts[T_CEND] = ts[T_CSTART] + words * cpw;
		ph = PH_COMPUTE;
		st = ST_BUSY;
		dl = ts[T_CEND];
		return 1'b1;
	endfunction

	function automatic logic advance_phase(logic [63:0] now, output logic [63:0] dl,
			output logic cp);
		logic [63:0] bytes, div;
		bytes = desc[D_WORDS] * 64'd8;
		div = (bw == 0) ? 64'd1 : bw;
		dl = '0;
		cp = 1'b0;
		if (ph == PH_COMPUTE) begin
			ts[T_LSTART] = (now > lfree) ? now : lfree;
			ts[T_QWAIT] = ts[T_LSTART] - now;
			lfree = ts[T_LSTART] + (bytes + div - 1) / div;
			ts[T_LEND] = lfree + lat;
			ph = PH_LINK;
			dl = ts[T_LEND];
			return 1'b1;
		end
		if (ph == PH_LINK) begin
			cmt = 1'b1;
			cp = 1'b1;
			ph = PH_RECORD;
			dl = now + (enf ? rec_dly : 64'd0);
			return 1'b1;
		end
		if (enf && desc[D_FAULT][1]) begin
			fail_job(ER_COMPLETION, now);
			return 1'b0;
		end
		if (enf) begin
			bump_records();
			cmpls++;
		end
		ts[T_FINISHED] = now;
		st = ST_DONE;
		return 1'b0;
	endfunction

	function automatic logic [63:0] window_read(logic [8:0] off, logic [3:0] sz,
			logic [63:0] now);
		if (off[2:0] != 3'd0 || sz != 4'd8)
			return '0;
		if (off >= OFF_DESC_LO && off <= OFF_DESC_HI)
			return desc[(off - OFF_DESC_LO) >> 3];
		if (off >= OFF_TS_LO && off <= OFF_TS_HI)
			return ts[(off - OFF_TS_LO) >> 3];
		case (off)
			OFF_ID:       return ID_VALUE;
			OFF_STATUS:   return 64'(st);
			OFF_ERROR:    return 64'(err);
			OFF_EPOCH:    return ep;
			OFF_CAP:      return cap;
			OFF_COUNT:    return cnt;
			OFF_COMMIT:   return 64'(cmt);
			OFF_REJECTED: return rej;
			OFF_POLICY:   return POLICY_VALUE;
			OFF_ENFORCE:  return 64'(enf);
			OFF_REC_DLY:  return rec_dly;
			OFF_CPW:      return cpw;
			OFF_BW:       return bw;
			OFF_LATENCY:  return lat;
			OFF_REQS:     return reqs;
			OFF_CMPLS:    return cmpls;
			OFF_FAILS:    return fails;
			OFF_NOW:      return now;
			default:      return '0;
		endcase
	endfunction

	function automatic logic window_write(logic [8:0] off, logic [3:0] sz, logic [63:0] v,
			logic [63:0] now, output logic [63:0] dl);
		dl = '0;
		if (sz != 4'd8 || off[2:0] != 3'd0 || st == ST_BUSY) begin
			rej++;
			return 1'b0;
		end
		if (off >= OFF_DESC_LO && off <= OFF_DESC_HI) begin
			desc[(off - OFF_DESC_LO) >> 3] = v;
			return 1'b0;
		end
		case (off)
			OFF_EPOCH:
				if (v <= ep) begin
					rej++;
				end else begin
					ep = v;
					cnt = '0;
					st = ST_IDLE;
					err = ER_NONE;
					cmt = 1'b0;
				end
			OFF_CAP:
				if (v < cnt || v > RECORD_LIMIT)
					rej++;
				else
					cap = v;
			OFF_START:
				if (v == 64'd1 && st != ST_PREFAIL && st != ST_POSTFAIL)
					return launch_job(now, dl);
				else
					rej++;
			default:
				rej++;
		endcase
		return 1'b0;
	endfunction

	function automatic bus_result_t predict_bus(logic [1:0] cmd, logic [8:0] off,
			logic [3:0] sz, logic [63:0] v, logic [63:0] now);
		bus_result_t r;
		logic [63:0] dl;
		logic cp;
		r = '0;
		dl = '0;
		cp = 1'b0;
		case (cmd)
			CMD_READ:  r.rd = window_read(off, sz, now);
			CMD_WRITE: r.arm = window_write(off, sz, v, now, dl);
			CMD_TIMER:
				if (st == ST_BUSY)
					r.arm = advance_phase(now, dl, cp);
			default: ;
		endcase
		r.dl = r.arm ? dl : 64'd0;
		r.cp = cp;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_result_t want;
		if (!arst_n) begin
			enf = 1'b0;
			rec_dly = '0;
			cpw = '0;
			bw = 64'd1;
			lat = '0;
			mem_size = '0;
			st = ST_IDLE;
			err = ER_NONE;
			ep = 64'd1;
			cap = RECORD_LIMIT;
			cnt = '0;
			cmt = 1'b0;
			ph = PH_COMPUTE;
			lfree = '0;
			rej = '0;
			reqs = '0;
			cmpls = '0;
			fails = '0;
			for (int i = 0; i < 8; i++)
				desc[i] = '0;
			for (int i = 0; i < 6; i++)
				ts[i] = '0;
			result_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ENFORCE: enf = cfg_data[0];
					CFG_REC_DLY: rec_dly = {32'd0, cfg_data[31:0]};
					CFG_CPW:     cpw = {32'd0, cfg_data[31:0]};
					CFG_BW:      bw = {32'd0, cfg_data[31:0]};
					CFG_LATENCY: lat = {32'd0, cfg_data[31:0]};
					CFG_MEM:     mem_size = {27'd0, cfg_data[36:0]};
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				result_q.push_back(predict_bus(command, reg_offset, access_bytes,
					write_value, now_time));
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result", read_value, '0);
				end else begin
					want = result_q.pop_front();
					if (read_value !== want.rd)
						report_mismatch("read_value", read_value, want.rd);
					if (timer_arm !== want.arm)
						report_mismatch("timer_arm", 64'(timer_arm), 64'(want.arm));
					if (timer_deadline !== want.dl)
						report_mismatch("timer_deadline", timer_deadline, want.dl);
					if (commit_pulse !== want.cp)
						report_mismatch("commit_pulse", 64'(commit_pulse), 64'(want.cp));
				end
			end
		end
	end

endmodule

@@ test/tb_top.sv @@
// Top of the testbench for the vector job gate register block: clock, reset,
// stimulus, ready/idle pressure, watchdog and verdict.
// Depends on vjg_pkg, vector_job_gate_registers and vjg_checker.
module tb_top import vjg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RECORD_LIMIT = 1024;
	localparam int WORD_LIMIT   = 65536;
	localparam int STALL_LIMIT  = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = CMD_READ;
	logic [8:0]  reg_offset = '0;
	logic [3:0]  access_bytes = 4'd8;
	logic [63:0] write_value = '0;
	logic [63:0] now_time = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] read_value;
	logic        timer_arm;
	logic [63:0] timer_deadline;
	logic        commit_pulse;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_ENFORCE;
	logic [63:0] cfg_data = '0;

	int          fail_count;
	int          pending;
	int          items_sent = 0;
	int          snd_idle_pct = 0;  // chance of a gap before a transaction
	int          rcv_idle_pct = 0;  // chance of out_ready low in a cycle
	int          hold_token = 0;    // bump to request one long receiver hold-off
	int          hold_seen = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	logic [63:0] cur_epoch = 64'd1; // epoch the block holds, tracked by stimulus
	logic [63:0] mem_bytes = '0;    // memory size currently configured

	always #5 clk = ~clk;

	vector_job_gate_registers #(
		.RECORD_LIMIT(RECORD_LIMIT),
		.WORD_LIMIT(WORD_LIMIT)
	) u_dut (.*);

	vjg_checker #(
		.RECORD_LIMIT(RECORD_LIMIT),
		.WORD_LIMIT(WORD_LIMIT)
	) u_checker (.*);

	// Receiver: random stalls, or a long hold-off on request so that the block
	// fills up and pushes back on its input.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= 300;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Watchdog: end the run when no channel moves a transaction for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one transaction and hold it until accepted. Valid stays high into
	// the next transaction unless a gap is inserted.
	task automatic send_item(logic [1:0] cmd, logic [8:0] off, logic [3:0] sz,
			logic [63:0] v, logic [63:0] t);
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		reg_offset <= off;
		access_bytes <= sz;
		write_value <= v;
		now_time <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Hold off the sender until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic en, logic [31:0] rd, logic [31:0] cw, logic [31:0] b,
			logic [31:0] lt, logic [63:0] mb);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		// upper bits beyond each register's width must be dropped by the block
		write_cfg(CFG_ENFORCE, {junk[63:1], en});
		write_cfg(CFG_REC_DLY, {junk[31:0], rd});
		write_cfg(CFG_CPW, {junk[63:32], cw});
		write_cfg(CFG_BW, {junk[31:0], b});
		write_cfg(CFG_LATENCY, {junk[63:32], lt});
		write_cfg(CFG_MEM, {junk[63:37], mb[36:0]});
		mem_bytes = mb;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_base(logic [63:0] words);
		logic [63:0] room, base;
		room = (mem_bytes > words * 8) ? (mem_bytes - words * 8) >> 3 : 64'd0;
		base = 64'($urandom_range(0, (room > 64'hffff) ? 32'hffff : 32'(room))) << 3;
		case ($urandom_range(19))
			0: base = base | 64'd4;        // misaligned
			1: base = mem_bytes + 64'd8;   // past the end
			2: base = rand64();
			default: ;
		endcase
		return base;
	endfunction

	function automatic logic [8:0] rand_offset();
		logic [8:0] off;
		off = 9'($urandom_range(0, 9'h108 >> 3)) << 3;
		if ($urandom_range(9) == 0)
			off = 9'($urandom);
		return off;
	endfunction

	// Noise: reads, stray writes, idle timers and the unused command. Epoch
	// writes here never exceed the tracked epoch so they stay rejected.
	task automatic noise_burst();
		logic [1:0]  cmd;
		logic [8:0]  off;
		logic [63:0] v;
		repeat ($urandom_range(2, 8)) begin
			cmd = 2'($urandom);
			off = rand_offset();
			v = rand64();
			if (off == OFF_EPOCH)
				v = cur_epoch;
			send_item(cmd, off, 4'($urandom_range(1, 8)), v, rand64());
		end
		// advance any job a stray start may have launched
		repeat (3) send_item(CMD_TIMER, 9'($urandom), 4'($urandom_range(1, 8)), rand64(),
			rand64());
	endtask

	// One well-formed job: optional epoch bump, descriptor, start, three
	// phase events, with reads mixed in. Fields are bent now and then.
	task automatic job_sequence();
		logic [63:0] t, words, rel, fault, jep;
		t = ($urandom_range(3) == 0) ? 64'($urandom) : rand64();
		if ($urandom_range(1) == 0) begin
			cur_epoch = cur_epoch + $urandom_range(1, 50);
			send_item(CMD_WRITE, OFF_EPOCH, 4'd8, cur_epoch, t);
			if ($urandom_range(3) == 0)
				send_item(CMD_WRITE, OFF_CAP, 4'd8, $urandom_range(0, RECORD_LIMIT + 2), t);
		end
		case ($urandom_range(29))
			0: words = WORD_LIMIT;
			1: words = 0;
			2: words = WORD_LIMIT + 1;
			default: words = $urandom_range(1, 64);
		endcase
		rel = t + (($urandom_range(19) == 0) ? 64'd1000000005 : 64'($urandom_range(0, 5000)));
		if ($urandom_range(29) == 0)
			rel = t - 1;
		fault = ($urandom_range(9) == 0) ? 64'($urandom_range(4, 9)) :
			64'($urandom_range(0, 3));
		jep = ($urandom_range(9) == 0) ? cur_epoch + 1 : cur_epoch;
		send_item(CMD_WRITE, OFF_DESC_LO, 4'd8, jep, t);
		send_item(CMD_WRITE, OFF_DESC_LO + 9'h08, 4'd8, rand64(), t);
		send_item(CMD_WRITE, OFF_DESC_LO + 9'h10, 4'd8, pick_base(words), t);
		send_item(CMD_WRITE, OFF_DESC_LO + 9'h18, 4'd8, pick_base(words), t);
		send_item(CMD_WRITE, OFF_DESC_LO + 9'h20, 4'd8, words, t);
		send_item(CMD_WRITE, OFF_DESC_LO + 9'h28, 4'd8, rand64(), t);
		send_item(CMD_WRITE, OFF_DESC_LO + 9'h30, 4'd8, rel, t);
		send_item(CMD_WRITE, OFF_DESC_HI, 4'd8, fault, t);
		send_item(CMD_WRITE, OFF_START, 4'd8, 64'd1, t);
		for (int p = 0; p < 3; p++) begin
			if ($urandom_range(2) == 0)
				send_item(CMD_READ, rand_offset(), 4'd8, rand64(), t);
			t = t + $urandom_range(0, 20000);
			send_item(CMD_TIMER, 9'($urandom), 4'($urandom_range(1, 8)), rand64(), t);
		end
		send_item(CMD_READ, OFF_STATUS, 4'd8, '0, t);
		send_item(CMD_READ, OFF_TS_LO + 9'($urandom_range(0, 5) << 3), 4'd8, '0, t);
	endtask

	task automatic random_phase(int target);
		while (items_sent < target) begin
			if (items_sent >= 700) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end else if (items_sent >= 350) begin
				snd_idle_pct = 74;
				rcv_idle_pct = 16;
			end
			if ($urandom_range(4) == 0)
				noise_burst();
			else
				job_sequence();
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: window corners and rejection paths with reset configuration.
		send_item(CMD_READ, OFF_ID, 4'd8, '0, '0);
		send_item(CMD_READ, OFF_POLICY, 4'd8, '0, '0);
		send_item(CMD_READ, OFF_NOW, 4'd8, '0, '1);
		send_item(CMD_READ, OFF_STATUS, 4'd4, '0, '0);      // short read
		send_item(CMD_READ, OFF_EPOCH + 9'd3, 4'd8, '0, '0); // misaligned read
		send_item(CMD_READ, 9'h1f8, 4'd8, '0, '0);           // unknown offset
		send_item(CMD_WRITE, OFF_DESC_LO, 4'd1, '1, '0);     // short write
		send_item(CMD_WRITE, 9'h1f8, 4'd8, '1, '0);          // unknown write offset
		send_item(CMD_WRITE, OFF_EPOCH, 4'd8, 64'd1, '0);    // epoch not larger
		send_item(CMD_WRITE, OFF_CAP, 4'd8, RECORD_LIMIT + 1, '0);
		send_item(CMD_WRITE, OFF_CAP, 4'd8, 64'd2, '0);
		send_item(CMD_WRITE, OFF_START, 4'd8, 64'd2, '0);    // start with wrong value
		send_item(CMD_WRITE, OFF_START, 4'd8, 64'd1, '0);    // job epoch 0 fails
		send_item(CMD_WRITE, OFF_START, 4'd8, 64'd1, '0);    // start while failed
		send_item(CMD_READ, OFF_ERROR, 4'd8, '0, '0);
		send_item(CMD_TIMER, '0, 4'd8, '0, '1);              // timer with no job running
		send_item(2'd3, OFF_ID, 4'd8, '1, '1);               // unused command
		cur_epoch = 64'd5;
		send_item(CMD_WRITE, OFF_EPOCH, 4'd8, cur_epoch, '0);
		send_item(CMD_WRITE, OFF_CAP, 4'd8, RECORD_LIMIT, '0);
		send_item(CMD_READ, OFF_REJECTED, 4'd8, '0, '0);
		send_item(CMD_READ, OFF_FAILS, 4'd8, '0, '0);
		drain();

		snd_idle_pct = 16;
		rcv_idle_pct = 74;
		set_config(1'b0, 32'd0, 32'd5, 32'd8, 32'd100, 64'd4096);
		hold_token++;
		random_phase(280);
		set_config(1'b1, 32'hffffffff, 32'hffffffff, 32'd0, 32'hffffffff, 64'd68719476736);
		random_phase(540);
		set_config(1'b1, 32'($urandom_range(0, 1000)), 32'($urandom_range(0, 50)), 32'd1,
			$urandom, 64'd4096);
		hold_token++;
		random_phase(800);
		set_config(1'b1, 32'd0, 32'd0, 32'hffffffff, 32'd0, 64'd0);
		random_phase(880);
		set_config(1'b1, 32'd7, 32'd3, 32'd3, 32'd9, 64'd65536);
		random_phase(1070);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
